// ===== design/kthlt_pkg.sv =====
// ----------------------------------------------------------------------------
// kthlt_pkg: shared types and constants of the k-th largest tracker
// Cell chain sizing, count widths, operation codes and the link and control
// records that travel between the cells and the top level.
// ----------------------------------------------------------------------------
package kthlt_pkg;

   localparam int MAX_K       = 64;
   localparam int VALUE_W     = 32;
   localparam int K_W         = 7;
   localparam int COUNT_W     = $clog2(MAX_K + 1);
   localparam int RSP_FIELD_W = VALUE_W + K_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   // What the chain does with the incoming value in this transaction.
   typedef enum logic [1:0] {
      OP_HOLD    = 2'd0,
      OP_INSERT  = 2'd1,
      OP_REPLACE = 2'd2
   } op_type;

   // Broadcast to every cell.
   typedef struct packed {
      logic                       step;   // a transaction is taken this cycle
      logic                       clear;  // empty the set before the value
      op_type                     op;
      logic signed [VALUE_W-1:0]  value;
   } ctrl_type;

   // What a cell shows its neighbors.
   typedef struct packed {
      logic                       valid;  // holds a value after any clear
      logic                       above;  // empty, or holds a value > incoming
      logic signed [VALUE_W-1:0]  value;
   } link_type;

endpackage

// ===== design/kthlt_cell.sv =====
// ----------------------------------------------------------------------------
// kthlt_cell: one compare-and-shift cell of the sorted chain
// Holds one value and a valid flag; on each transaction keeps its value,
// takes the incoming value, or takes a neighbor's value.
// ----------------------------------------------------------------------------
module kthlt_cell (
   input  logic                clock,
   input  logic                reset,
   input  kthlt_pkg::ctrl_type ctrl,
   input  kthlt_pkg::link_type lower,     // neighbor one place down
   input  kthlt_pkg::link_type upper,     // neighbor one place up
   output kthlt_pkg::link_type self_link,
   output logic [kthlt_pkg::VALUE_W-1:0] value_next
);
   import kthlt_pkg::*;

   logic                      valid_ff, valid_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      eff_valid;

   assign eff_valid = valid_ff & ~ctrl.clear;

   assign self_link.valid = eff_valid;
   assign self_link.above = ~eff_valid | (value_ff > ctrl.value);
   assign self_link.value = value_ff;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.step) begin
         valid_in = eff_valid;
         unique case (ctrl.op)
            OP_INSERT: begin
               // shift up everything above the new value, grow by one
               valid_in = lower.valid;
               if (lower.above) begin
                  value_in = lower.value;
               end else if (self_link.above) begin
                  value_in = ctrl.value;
               end
            end
            OP_REPLACE: begin
               // drop the smallest: shift down what stays below the new value
               if (upper.valid && !upper.above) begin
                  value_in = upper.value;
               end else if (!self_link.above) begin
                  value_in = ctrl.value;
               end
            end
            OP_HOLD: begin
            end
            default: begin
            end
         endcase
      end
   end

   assign value_next = value_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

endmodule

// ===== design/kthlt_outq.sv =====
// ----------------------------------------------------------------------------
// kthlt_outq: two-entry result queue
// Holds finished results so the chain can take a new transaction while an
// earlier result still waits on the output side.
// ----------------------------------------------------------------------------
module kthlt_outq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  logic [kthlt_pkg::RSP_FIELD_W-1:0]   push_data,
   output logic                                full,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [kthlt_pkg::RSP_FIELD_W-1:0]   out_data
);
   import kthlt_pkg::*;

   logic [RSP_FIELD_W-1:0] entry_ff [2];
   logic                   head_ff, head_in;
   logic                   tail_ff, tail_in;
   logic [1:0]             fill_ff, fill_in;
   logic                   pop;

   assign full      = (fill_ff == 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_data  = entry_ff[head_ff];
   assign pop       = out_valid & out_ready;

   always_comb begin
      head_in = pop  ? ~head_ff : head_ff;
      tail_in = push ? ~tail_ff : tail_ff;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= 1'b0;
         tail_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

endmodule

// ===== design/stream_kth_largest_tracker.sv =====
// ----------------------------------------------------------------------------
// stream_kth_largest_tracker: k largest values of a signed stream
// Sorted chain of compare-and-shift cells, smallest value in cell 0.
// Each result is registered into the result queue as its transaction is taken.
// Throughput: one transaction per cycle unless stalled; the cell chain inserts in one step.
// The two-entry result queue stalls input only when both entries are full.
// Reset (synchronous): empties the set, empties the queue, sets k to 1.
// ----------------------------------------------------------------------------
module stream_kth_largest_tracker (
   input  logic        clock,
   input  logic        reset,
   // configuration: k_in_use
   input  logic        csr_wen,
   input  logic [6:0]  csr_wdata,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [0:0]  req_tuser,   // [0] first_of_set
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [kthlt_pkg::RSP_DATA_W-1:0] rsp_tdata  // [31:0] kth_value,
                                                      // [38:32] held_count
);
   import kthlt_pkg::*;

   logic [K_W-1:0]     k_ff, k_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] eff_count;
   logic [COUNT_W-1:0] work_k;
   logic               take;
   logic               full;
   ctrl_type           ctrl;
   link_type           links [MAX_K];
   logic [VALUE_W-1:0] next_vals [MAX_K];
   logic [RSP_FIELD_W-1:0] q_data;

   // Hold k; clamp it into 1..MAX_K when used.
   assign k_in = csr_wen ? csr_wdata : k_ff;

   always_comb begin
      if (k_ff == '0) begin
         work_k = COUNT_W'(1);
      end else if (COUNT_W'(k_ff) > COUNT_W'(MAX_K)) begin
         work_k = COUNT_W'(MAX_K);
      end else begin
         work_k = COUNT_W'(k_ff);
      end
   end

   assign req_tready = ~full;
   assign take       = req_tvalid & req_tready;

   // Pick the chain operation: grow while short, else replace the smallest
   // when the new value is strictly greater, else drop the value.
   assign eff_count = req_tuser[0] ? '0 : count_ff;

   always_comb begin
      ctrl.step  = take;
      ctrl.clear = req_tuser[0];
      ctrl.value = req_tdata;
      if (eff_count < work_k) begin
         ctrl.op = OP_INSERT;
      end else if (links[0].valid && !links[0].above
                   && (links[0].value != $signed(req_tdata))) begin
         ctrl.op = OP_REPLACE;
      end else begin
         ctrl.op = OP_HOLD;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (take) begin
         count_in = (ctrl.op == OP_INSERT) ? eff_count + COUNT_W'(1) : eff_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= K_W'(1);
         count_ff <= '0;
      end else begin
         k_ff     <= k_in;
         count_ff <= count_in;
      end
   end

   // The cell chain; the ends see an always-full floor and an empty ceiling.
   localparam link_type FLOOR_LINK = '{valid: 1'b1, above: 1'b0, value: '0};
   localparam link_type CEIL_LINK  = '{valid: 1'b0, above: 1'b1, value: '0};

   for (genvar i = 0; i < MAX_K; i++) begin : g_cell
      link_type lower_link, upper_link;
      if (i == 0) begin : g_lo_end
         assign lower_link = FLOOR_LINK;
      end else begin : g_lo_mid
         assign lower_link = links[i-1];
      end
      if (i == MAX_K - 1) begin : g_hi_end
         assign upper_link = CEIL_LINK;
      end else begin : g_hi_mid
         assign upper_link = links[i+1];
      end
      kthlt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .lower      (lower_link),
         .upper      (upper_link),
         .self_link  (links[i]),
         .value_next (next_vals[i])
      );
   end

   // Queue the post-update smallest value and the count held.
   kthlt_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_data ({K_W'(count_in), next_vals[0]}),
      .full      (full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (q_data)
   );

   assign rsp_tdata = {{(RSP_DATA_W - RSP_FIELD_W){1'b0}}, q_data};

endmodule
